>>> rtl/core/msrc_pkg.sv
// Package for the multi-axis servo ramp controller: widths, codes, payload types.
// Used by every module in rtl/core; depends on nothing.
package msrc_pkg;
	localparam int AXES = 8;
	localparam int ANGLE_WIDTH = 24;
	localparam int AXW = 3;
	localparam int SPW = 16;
	localparam int DW = ANGLE_WIDTH + 1;          // distance width
	localparam int PW = SPW + DW;                 // product width
	localparam logic [SPW-1:0] BASE_SPEED_RESET = 16'd26;

	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_SETPT  = 3'd1;
	localparam logic [2:0] CMD_ENABLE = 3'd2;
	localparam logic [2:0] CMD_PRESET = 3'd3;
	localparam logic [2:0] CMD_COORD  = 3'd4;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [2:0]         axis;
		logic signed [23:0] value;
		logic               enable;
		logic [3:0]         count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         axis_out;
		logic signed [23:0] position;
		logic [15:0]        speed;
		logic               busy_res;
		logic               last;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NONE  = 4'b0001,
		OP_STEP  = 4'b0010,
		OP_WRITE = 4'b0100,
		OP_SCAN  = 4'b1000
	} dp_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		dp_op_t         op;
		logic [AXW-1:0] idx;
		logic           scan_first;
		logic           div_start;   // start scaling of axis idx
		logic           emit;        // load output register from axis idx
		logic           last;
	} dp_cmd_t;

	typedef struct packed {
		logic           div_done;
		logic           big_zero;
		logic [AXW-1:0] big_idx;
	} dp_sts_t;
endpackage

>>> rtl/core/msrc_div.sv
// Restoring divider, one quotient bit per cycle, for speed rescaling.
// Depends on msrc_pkg.
module msrc_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [msrc_pkg::PW-1:0] num,
	input  logic [msrc_pkg::DW-1:0] den,
	output logic                    done,
	output logic [msrc_pkg::PW-1:0] quo
);
	import msrc_pkg::*;
	localparam int CW = $clog2(PW + 1);
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [DW:0]   rem_q;
	logic [PW-1:0] q_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;

	assign trial = {rem_q[DW-1:0], q_q[PW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(PW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num;
			den_q <= den;
		end else if (run_q) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				q_q   <= {q_q[PW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-1:0], q_q[PW-1]};
				q_q   <= {q_q[PW-2:0], 1'b0};
			end
		end
	end
	assign quo = q_q;
endmodule

>>> rtl/core/msrc_datapath.sv
// Axis state registers, step, scan and output register of the controller.
// Depends on msrc_pkg and msrc_div.
module msrc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          base_speed,
	input  msrc_pkg::in_item_t   item,
	input  msrc_pkg::dp_cmd_t    dcmd,
	output msrc_pkg::dp_sts_t    sts,
	output msrc_pkg::out_item_t  res
);
	import msrc_pkg::*;
	localparam logic signed [ANGLE_WIDTH+1:0] AMAX =
		(ANGLE_WIDTH+2)'((1 <<< (ANGLE_WIDTH - 1)) - 1);
	localparam logic signed [ANGLE_WIDTH+1:0] AMIN =
		(ANGLE_WIDTH+2)'(-(1 <<< (ANGLE_WIDTH - 1)));

	logic signed [ANGLE_WIDTH-1:0] pos_q [AXES];
	logic signed [ANGLE_WIDTH-1:0] set_q [AXES];
	logic [SPW-1:0]                spd_q [AXES];
	logic [AXES-1:0]               en_q, busy_q;
	logic [DW-1:0]                 big_q;
	logic [AXW-1:0]                bi_q;
	logic                          div_done;
	logic [PW-1:0]                 quo;

	logic signed [ANGLE_WIDTH+1:0] p, s, v, val;
	logic [DW-1:0]                 dist_abs;
	logic                          far;
	logic signed [ANGLE_WIDTH+1:0] nxt, nsat;

	always_comb begin
		p    = (ANGLE_WIDTH+2)'(pos_q[dcmd.idx]);
		s    = (ANGLE_WIDTH+2)'(set_q[dcmd.idx]);
		v    = $signed({{(ANGLE_WIDTH+2-SPW){1'b0}}, spd_q[dcmd.idx]});
		val  = (ANGLE_WIDTH+2)'(item.value);
		if (val > AMAX) val = AMAX;
		if (val < AMIN) val = AMIN;
		far  = (s < p - v) || (s > p + v);
		nxt  = (s > p) ? p + v : p - v;
		nsat = nxt;
		if (nxt > AMAX) nsat = AMAX;
		if (nxt < AMIN) nsat = AMIN;
		dist_abs = (s > p) ? DW'(s - p) : DW'(p - s);
	end

	msrc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dcmd.div_start),
		.num(PW'(spd_q[dcmd.idx]) * PW'(dist_abs)), .den(big_q),
		.done(div_done), .quo(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= '0;
			busy_q <= '0;
			for (int i = 0; i < AXES; i++) begin
				pos_q[i] <= '0;
				set_q[i] <= '0;
				spd_q[i] <= BASE_SPEED_RESET;
			end
		end else begin
			unique case (dcmd.op)
				OP_STEP: begin
					if (en_q[dcmd.idx]) begin
						busy_q[dcmd.idx] <= far;
						if (far) pos_q[dcmd.idx] <= ANGLE_WIDTH'(nsat);
					end
				end
				OP_WRITE: begin
					unique case (item.cmd)
						CMD_SETPT: set_q[dcmd.idx] <= ANGLE_WIDTH'(val);
						CMD_ENABLE: en_q[dcmd.idx] <= item.enable;
						default: begin
							pos_q[dcmd.idx]  <= ANGLE_WIDTH'(val);
							set_q[dcmd.idx]  <= ANGLE_WIDTH'(val);
							en_q[dcmd.idx]   <= 1'b0;
							busy_q[dcmd.idx] <= 1'b0;
							spd_q[dcmd.idx]  <= base_speed;
						end
					endcase
				end
				default: ;
			endcase
			if (div_done) spd_q[dcmd.idx] <= SPW'(quo);
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.op == OP_SCAN) begin
			if (dcmd.scan_first || dist_abs > big_q) begin
				big_q <= dist_abs;
				bi_q  <= dcmd.idx;
			end
		end
		if (dcmd.emit) begin
			res.axis_out <= dcmd.idx;
			res.position <= pos_q[dcmd.idx];
			res.speed    <= spd_q[dcmd.idx];
			res.busy_res <= busy_q[dcmd.idx];
			res.last     <= dcmd.last;
		end
	end

	assign sts.div_done = div_done;
	assign sts.big_zero = (big_q == '0);
	assign sts.big_idx  = bi_q;
endmodule

>>> rtl/core/msrc_ctrl.sv
// Sequencer of the controller: accepts commands, walks axes, drives transfers.
// Depends on msrc_pkg.
module msrc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  msrc_pkg::in_item_t in_data,
	output msrc_pkg::in_item_t item,
	output logic               out_valid,
	input  logic               out_ready,
	output msrc_pkg::dp_cmd_t  dcmd,
	input  msrc_pkg::dp_sts_t  sts
);
	import msrc_pkg::*;
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001, S_STEP = 7'b0000010, S_WRITE = 7'b0000100,
		S_SCAN = 7'b0001000, S_SCALE = 7'b0010000, S_WAIT = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t         state_q;
	logic [AXW:0]   i_q, n_q;
	logic           ovalid_q;
	logic [3:0]     ncl;

	assign ncl = (in_data.count > 4'(AXES)) ? 4'(AXES) : in_data.count;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;

	always_comb begin
		dcmd = '0;
		dcmd.op  = OP_NONE;
		dcmd.idx = i_q[AXW-1:0];
		dcmd.last = (i_q + 1'b1 == n_q);
		unique case (state_q)
			S_STEP:  dcmd.op = OP_STEP;
			S_WRITE: begin dcmd.op = OP_WRITE; dcmd.idx = item.axis; end
			S_SCAN:  begin dcmd.op = OP_SCAN; dcmd.scan_first = (i_q == '0); end
			S_SCALE: dcmd.div_start = (i_q[AXW-1:0] != sts.big_idx) && !sts.big_zero;
			S_EMIT:  begin
				dcmd.emit = !ovalid_q || out_ready;
				if (item.cmd != CMD_TICK && item.cmd != CMD_COORD) begin
					dcmd.idx  = item.axis;
					dcmd.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			i_q      <= '0;
			n_q      <= '0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					i_q <= '0;
					unique case (in_data.cmd) inside
						CMD_TICK: begin state_q <= S_STEP; n_q <= (AXW+1)'(AXES); end
						CMD_SETPT, CMD_ENABLE, CMD_PRESET: state_q <= S_WRITE;
						CMD_COORD: if (ncl != 0) begin
							state_q <= S_SCAN; n_q <= ncl;
						end
						default: ;
					endcase
				end
				S_STEP: begin
					if (dcmd.last) begin state_q <= S_EMIT; i_q <= '0; end
					else i_q <= i_q + 1'b1;
				end
				S_WRITE: state_q <= S_EMIT;
				S_SCAN: begin
					if (dcmd.last) begin state_q <= S_SCALE; i_q <= '0; end
					else i_q <= i_q + 1'b1;
				end
				S_SCALE: begin
					if (dcmd.div_start) state_q <= S_WAIT;
					else if (dcmd.last) begin state_q <= S_EMIT; i_q <= '0; end
					else i_q <= i_q + 1'b1;
				end
				S_WAIT: if (sts.div_done) begin
					if (dcmd.last) begin state_q <= S_EMIT; i_q <= '0; end
					else begin state_q <= S_SCALE; i_q <= i_q + 1'b1; end
				end
				S_EMIT: if (dcmd.emit) begin
					ovalid_q <= 1'b1;
					if (dcmd.last) state_q <= S_IDLE;
					else i_q <= i_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item <= in_data;
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("accept while busy");
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ready) |-> !dcmd.emit) else $error("result overwritten");
	a_wait_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) |-> !dcmd.div_start) else $error("divider restarted");
`endif
endmodule

>>> rtl/core/multi_axis_servo_ramp_controller.sv
// Top level of the eight-axis servo ramp controller.
// Depends on msrc_pkg, msrc_ctrl and msrc_datapath.
//
// Usage: commands arrive on the in channel (valid/ready); each transfer is
// one command. Results leave on the out channel, one axis per transfer, with
// last set on the final result of a command. A tick yields eight results,
// set setpoint, enable and preset one, coordinate one per counted axis;
// unused codes, count zero yield none.
// Sequence: a single-axis command writes its axis, then emits its result;
// a tick steps all eight axes, then emits one result per axis. Coordinate
// scans the counted axes, then scales each one in the bit-serial divider
// (one quotient bit per cycle over the 41-bit speed times distance
// product), skipping the axis of largest distance and, if that distance is
// zero, every axis; then it emits one result per counted axis.
// Only one command is in work at a time; the next is accepted once the
// sequencer is idle again, while the final result may still wait in the
// output register.
// Reset clears positions, setpoints, enables and busy flags, loads speed 26
// into every axis and into base_speed. When the receiver stalls, the result
// register holds its transfer and the sequencer waits.
module multi_axis_servo_ramp_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  msrc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output msrc_pkg::out_item_t out_data
);
	import msrc_pkg::*;
	logic [15:0] base_speed_q;
	in_item_t    item;
	dp_cmd_t     dcmd;
	dp_sts_t     sts;

	// The preset speed register is written directly from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_speed_q <= BASE_SPEED_RESET;
		else if (cfg_we) base_speed_q <= cfg_wdata;
	end

	msrc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .item(item), .out_valid(out_valid),
		.out_ready(out_ready), .dcmd(dcmd), .sts(sts)
	);

	msrc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .base_speed(base_speed_q), .item(item),
		.dcmd(dcmd), .sts(sts), .res(out_data)
	);
endmodule

>>> test/msrc_scoreboard.sv
// Checker for the servo ramp controller: predicts the results of every
// command transfer and compares them with the result transfers. Depends on msrc_pkg.
`timescale 1ns / 1ps

module msrc_scoreboard (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  msrc_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  msrc_pkg::out_item_t out_data,
	output int                  errors,
	output int                  pending
);
	import msrc_pkg::*;
	logic signed [ANGLE_WIDTH-1:0] pos [AXES];
	logic signed [ANGLE_WIDTH-1:0] setpt [AXES];
	logic [15:0] spd [AXES];
	logic        on [AXES];
	logic        moving [AXES];
	logic [15:0] preset_speed;
	out_item_t   expected_results [$];

	assign pending = expected_results.size();

	function automatic out_item_t axis_report(int a, bit fin);
		out_item_t r;
		r.axis_out = a[2:0];
		r.position = pos[a];
		r.speed = spd[a];
		r.busy_res = moving[a];
		r.last = fin;
		return r;
	endfunction

	task automatic predict_command(in_item_t it);
		longint p, s, v, big, d, n;
		int bi;
		case (it.cmd) inside
			CMD_TICK: begin
				for (int a = 0; a < AXES; a++) begin
					p = pos[a];
					s = setpt[a];
					v = spd[a];
					if (on[a]) begin
						if (s < p - v || s > p + v) begin
							moving[a] = 1'b1;
							p = (s > p) ? p + v : p - v;
							if (p > 8388607) p = 8388607;
							if (p < -8388608) p = -8388608;
							pos[a] = p[ANGLE_WIDTH-1:0];
						end else begin
							moving[a] = 1'b0;
						end
					end
				end
				for (int a = 0; a < AXES; a++)
					expected_results.push_back(axis_report(a, a == AXES - 1));
			end
			CMD_SETPT, CMD_ENABLE, CMD_PRESET: begin
				if (it.cmd == CMD_SETPT) begin
					setpt[it.axis] = it.value;
				end else if (it.cmd == CMD_ENABLE) begin
					on[it.axis] = it.enable;
				end else begin
					pos[it.axis] = it.value;
					setpt[it.axis] = it.value;
					on[it.axis] = 1'b0;
					moving[it.axis] = 1'b0;
					spd[it.axis] = preset_speed;
				end
				expected_results.push_back(axis_report(it.axis, 1'b1));
			end
			CMD_COORD: begin
				n = (it.count > AXES) ? AXES : it.count;
				if (n != 0) begin
					bi = 0;
					big = 0;
					for (int a = 0; a < n; a++) begin
						d = longint'(setpt[a]) - longint'(pos[a]);
						if (d < 0) d = -d;
						if (a == 0 || d > big) begin
							big = d;
							bi = a;
						end
					end
					if (big != 0) begin
						for (int a = 0; a < n; a++) begin
							if (a != bi) begin
								d = longint'(setpt[a]) - longint'(pos[a]);
								if (d < 0) d = -d;
								d = (longint'(spd[a]) * d) / big;
								spd[a] = d[15:0];
							end
						end
					end
					for (int a = 0; a < n; a++)
						expected_results.push_back(axis_report(a, a == n - 1));
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			errors <= 0;
			preset_speed = BASE_SPEED_RESET;
			expected_results.delete();
			for (int a = 0; a < AXES; a++) begin
				pos[a] = '0;
				setpt[a] = '0;
				spd[a] = BASE_SPEED_RESET;
				on[a] = 1'b0;
				moving[a] = 1'b0;
			end
		end else begin
			if (cfg_we)
				preset_speed = cfg_wdata;
			if (in_valid && in_ready)
				predict_command(in_data);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: %p", out_data);
					errors <= errors + 1;
				end else begin
					e = expected_results.pop_front();
					if (e !== out_data) begin
						if (errors < 10)
							$display("mismatch: expected %p actual %p", e, out_data);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

>>> test/multi_axis_servo_ramp_controller_test.sv
// Testbench top for the servo ramp controller: clock, reset, stimulus and
// verdict. Depends on msrc_pkg, the controller and msrc_scoreboard.
`timescale 1ns / 1ps

module multi_axis_servo_ramp_controller_test;
	import msrc_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [15:0] cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	int        errors;
	int        pending;
	int        idle_cycles;
	bit        timed_out;

	// The watchdog limit covers the slowest command: a coordinate over eight
	// axes runs the divider for each scaled axis before its first result, and
	// the receiver may stall on each of its results.
	localparam int WATCHDOG_LIMIT = 4000;

	multi_axis_servo_ramp_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	msrc_scoreboard checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver alternates between random runs of readiness, some long, and
	// random stalls, so results back up inside the block at every phase.
	initial begin
		int run;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 10);
			repeat (run) begin
				@(posedge clk);
				out_ready <= 1'b1;
			end
			run = $urandom_range(0, 15);
			repeat (run) begin
				@(posedge clk);
				out_ready <= 1'b0;
			end
		end
	end

	// Watchdog: counts cycles in which no transfer happens on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		timed_out = 1'b1;
		$display("multi_axis_servo_ramp_controller_test: done, errors");
		$finish;
	end

	int burst_left;

	// Sends one command transfer. The sender works in bursts: once a burst
	// runs out it drops valid for a random gap before the next burst starts.
	// Valid drops after each transfer, within a burst as well.
	task automatic send(input logic [2:0] c, input logic [2:0] a,
	                    input logic signed [23:0] v, input logic en,
	                    input logic [3:0] n);
		in_item_t it;
		int gap;
		it.cmd = c;
		it.axis = a;
		it.value = v;
		it.enable = en;
		it.count = n;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(posedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 8);
		end
		@(posedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!(in_valid && in_ready));
		in_valid <= 1'b0;
		burst_left--;
	endtask

	// Waits for every expected result (or the watchdog), then lets the block
	// settle long enough to finish any command that has no result.
	task automatic drain();
		wait (pending == 0 || timed_out);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_base_speed(input logic [15:0] s);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [23:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 24'(24'sh7FFFFF - $urandom_range(0, 40));
			1: return 24'(24'sh800000 + $urandom_range(0, 40));
			2: return 24'($urandom);
			default: return 24'($signed($urandom_range(0, 8000)) - 4000);
		endcase
	endfunction

	// A random command, weighted toward well-formed moves: setpoints, enables
	// and ticks dominate, with presets, coordinates and unused codes mixed in.
	task automatic random_command();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			send(CMD_TICK, 3'($urandom), 24'($urandom), 1'($urandom), 4'($urandom));
		else if (pick < 55)
			send(CMD_SETPT, 3'($urandom), rand_angle(), 1'($urandom), 4'($urandom));
		else if (pick < 70)
			send(CMD_ENABLE, 3'($urandom), 24'($urandom),
			     $urandom_range(0, 3) != 0, 4'($urandom));
		else if (pick < 80)
			send(CMD_PRESET, 3'($urandom), rand_angle(), 1'($urandom), 4'($urandom));
		else if (pick < 95)
			send(CMD_COORD, 3'($urandom), 24'($urandom), 1'($urandom),
			     4'($urandom_range(0, 15)));
		else
			send(3'($urandom_range(5, 7)), 3'($urandom), 24'($urandom),
			     1'($urandom), 4'($urandom));
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: extremes, every command, unused codes, count zero and
		// count above eight.
		write_base_speed(16'hFFFF);
		send(CMD_PRESET, 3'd0, 24'sh7FFFF0, 1'b0, 4'd0);
		send(CMD_PRESET, 3'd7, 24'sh800010, 1'b1, 4'd15);
		send(CMD_SETPT, 3'd0, 24'sh800000, 1'b0, 4'd0);
		send(CMD_SETPT, 3'd7, 24'sh7FFFFF, 1'b0, 4'd0);
		send(CMD_ENABLE, 3'd0, 24'sh0, 1'b1, 4'd0);
		send(CMD_ENABLE, 3'd7, 24'shFFFFFF, 1'b1, 4'd0);
		send(CMD_COORD, 3'd0, 24'sh0, 1'b0, 4'd15);
		send(CMD_TICK, 3'd0, 24'sh0, 1'b0, 4'd0);
		send(CMD_TICK, 3'd7, 24'sh555555, 1'b1, 4'd8);
		send(CMD_COORD, 3'd0, 24'sh0, 1'b0, 4'd0);
		send(3'd5, 3'd1, 24'sh0, 1'b0, 4'd1);
		send(3'd6, 3'd2, 24'sh0, 1'b0, 4'd2);
		send(3'd7, 3'd3, 24'sh0, 1'b0, 4'd3);
		send(CMD_ENABLE, 3'd7, 24'sh0, 1'b0, 4'd0);
		send(CMD_TICK, 3'd0, 24'sh0, 1'b0, 4'd0);

		// Hold off until the block has delivered everything, then go on.
		drain();
		write_base_speed(16'd0);
		send(CMD_PRESET, 3'd3, 24'sh000100, 1'b0, 4'd0);
		send(CMD_COORD, 3'd0, 24'sh0, 1'b0, 4'd8);
		send(CMD_COORD, 3'd0, 24'sh0, 1'b0, 4'd1);
		write_base_speed(BASE_SPEED_RESET);

		// Random part in phases, each under its own base speed.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				1: write_base_speed(16'($urandom_range(1, 2000)));
				2: write_base_speed(16'hFFFF);
				3: write_base_speed(16'($urandom));
				default: ;
			endcase
			for (int i = 0; i < 60; i++) begin
				if (phase == 0 && i < 8)
					send(CMD_PRESET, 3'(i), rand_angle(), 1'b0, 4'd0);
				else
					random_command();
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (timed_out) begin
			$display("multi_axis_servo_ramp_controller_test: done, errors");
		end else if (errors == 0) begin
			$display("multi_axis_servo_ramp_controller_test: done, clean");
		end else begin
			$display("multi_axis_servo_ramp_controller_test: done, errors");
		end
		$finish;
	end
endmodule

>>> filelist.f
rtl/core/msrc_pkg.sv
rtl/core/msrc_div.sv
rtl/core/msrc_datapath.sv
rtl/core/msrc_ctrl.sv
rtl/core/multi_axis_servo_ramp_controller.sv
test/msrc_scoreboard.sv
test/multi_axis_servo_ramp_controller_test.sv
